@@ sv/rrrs_pkg.sv @@
// Shared types and fixed field widths for the round-robin range read server.
`default_nettype none

package rrrs_pkg;

   // Fixed field widths of the request and response words
   localparam int IDX_W      = 11;
   localparam int LD_ADDR_W  = 10;
   localparam int DATA_W     = 32;
   localparam int ELEM_OUT_W = 3;

   // Function codes of a request word
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_SLOT = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [LD_ADDR_W-1:0]  load_addr;
      logic [DATA_W-1:0]     load_data;
      logic                  req_valid;
      logic                  req_last;
      logic [IDX_W-1:0]      req_start;
      logic [IDX_W-1:0]      req_stop;
      logic                  out_room;
   } req_type;

   typedef struct packed {
      logic [ELEM_OUT_W-1:0] slot_element;
      logic                  req_taken;
      logic                  data_valid;
      logic [DATA_W-1:0]     data_word;
      logic                  all_done;
   } rsp_type;

   // Decision of one service slot, handed from the scheduler to the read path
   typedef struct packed {
      logic [ELEM_OUT_W-1:0] element;
      logic                  taken;
      logic                  send;
      logic [IDX_W-1:0]      index;
      logic                  all_done;
   } slot_type;

endpackage

`default_nettype wire

@@ sv/rrrs_slot_ctrl.sv @@
// Round-robin element scheduler: per-element flags, range descriptors and slot pointer.
`default_nettype none

module rrrs_slot_ctrl #(
   parameter int NUM_ELEMENTS = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               slot_fire,
   input  rrrs_pkg::req_type req_in,
   output rrrs_pkg::slot_type slot_out
);

   localparam int PTR_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

   logic [NUM_ELEMENTS-1:0] active_ff, active_in;
   logic [NUM_ELEMENTS-1:0] streaming_ff, streaming_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;

   logic [rrrs_pkg::IDX_W-1:0] read_idx_ff [NUM_ELEMENTS];
   logic [rrrs_pkg::IDX_W-1:0] stop_idx_ff [NUM_ELEMENTS];

   logic [rrrs_pkg::IDX_W-1:0] cur_read;
   logic [rrrs_pkg::IDX_W-1:0] cur_stop;
   logic                       latch_range;
   logic                       advance;
   logic                       taken;
   logic                       send;

   always_comb begin
      cur_read     = read_idx_ff[ptr_ff];
      cur_stop     = stop_idx_ff[ptr_ff];
      active_in    = active_ff;
      streaming_in = streaming_ff;
      latch_range  = 1'b0;
      advance      = 1'b0;
      taken        = 1'b0;
      send         = 1'b0;
      if (active_ff[ptr_ff]) begin
         if (!streaming_ff[ptr_ff]) begin
            if (req_in.req_valid) begin
               taken = 1'b1;
               if (req_in.req_last) begin
                  active_in[ptr_ff] = 1'b0;
               end else begin
                  streaming_in[ptr_ff] = 1'b1;
                  latch_range          = 1'b1;
               end
            end
         end else if (cur_read >= cur_stop) begin
            streaming_in[ptr_ff] = 1'b0;
         end else if (req_in.out_room) begin
            send    = 1'b1;
            advance = 1'b1;
         end
      end
      ptr_in = (ptr_ff == PTR_W'(NUM_ELEMENTS - 1)) ? '0 : ptr_ff + 1'b1;
   end

   always_comb begin
      slot_out.element  = rrrs_pkg::ELEM_OUT_W'(ptr_ff);
      slot_out.taken    = taken;
      slot_out.send     = send;
      slot_out.index    = cur_read;
      slot_out.all_done = (active_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '1;
         streaming_ff <= '0;
         ptr_ff       <= '0;
      end else if (slot_fire) begin
         active_ff    <= active_in;
         streaming_ff <= streaming_in;
         ptr_ff       <= ptr_in;
      end
   end

   // Range descriptors: written only when a request latches them or a word goes out
   always_ff @(posedge clock) begin
      if (slot_fire && latch_range) begin
         read_idx_ff[ptr_ff] <= req_in.req_start;
         stop_idx_ff[ptr_ff] <= req_in.req_stop;
      end else if (slot_fire && advance) begin
         read_idx_ff[ptr_ff] <= cur_read + 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ sv/round_robin_range_read_server_unit.sv @@
// Top level of the round-robin range read server: source memory and response pipeline.
//
// Usage: the req_ channel carries one word per item. A load word (func = load)
// writes load_data into the source memory at load_addr and gives no response;
// loads at or beyond MEM_DEPTH are dropped. A slot word (func = slot) serves
// the element under the round-robin slot pointer: an idle active element takes
// an offered request (an end-marked one retires it), a streaming element sends
// the memory word at its read index when out_room is set, or goes idle once the
// index reaches its stop index. Each slot word gives exactly one rsp_ word.
// The accepting edge loads the read stage and the memory read; the output
// register then takes the word and raises rsp_valid once rsp_stall allows.
// Throughput: one word per cycle on req_ while req_stall is low, bounded by the
// single-port source memory, which serves one load write or one streamed read per cycle.
// Reset clears the slot pointer to element 0, marks all elements active and
// idle; the memory and range descriptors keep no reset value.
// When rsp_stall is high the output register holds its word; one more slot
// word may enter the read stage, after which req_stall rises until the
// output drains.
`default_nettype none

module round_robin_range_read_server_unit #(
   parameter int NUM_ELEMENTS = 8,
   parameter int MEM_DEPTH    = 1024,
   parameter int WORD_BITS    = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  rrrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output rrrs_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   logic req_accept;
   logic slot_fire;
   logic load_fire;
   logic read_fire;
   logic read_in_range;

   rrrs_pkg::slot_type slot;

   // Source memory and its registered read port
   logic [WORD_BITS-1:0] mem [MEM_DEPTH];
   logic [WORD_BITS-1:0] rd_word_ff;

   // Read stage: slot decision waiting for the memory word
   logic              s1_valid_ff, s1_valid_in;
   rrrs_pkg::rsp_type s1_rsp_ff;
   logic              s1_use_mem_ff;
   logic              s1_move;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   rrrs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Stall input only while the read stage holds a word the output cannot take
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign slot_fire  = req_accept && (req_data.func == rrrs_pkg::FUNC_SLOT);
   assign load_fire  = req_accept && (req_data.func == rrrs_pkg::FUNC_LOAD)
                       && (32'(req_data.load_addr) < 32'(MEM_DEPTH));

   rrrs_slot_ctrl #(
      .NUM_ELEMENTS (NUM_ELEMENTS)
   ) u_slot_ctrl (
      .clock     (clock),
      .reset     (reset),
      .slot_fire (slot_fire),
      .req_in    (req_data),
      .slot_out  (slot)
   );

   // An index past the memory sends a zero word; skip the read in that case
   assign read_in_range = (32'(slot.index) < 32'(MEM_DEPTH));
   assign read_fire     = slot_fire && slot.send && read_in_range;

   always_ff @(posedge clock) begin
      if (load_fire) begin
         mem[ADDR_W'(req_data.load_addr)] <= WORD_BITS'(req_data.load_data);
      end
   end

   always_ff @(posedge clock) begin
      if (read_fire) begin
         rd_word_ff <= mem[ADDR_W'(slot.index)];
      end
   end

   always_comb begin
      if (slot_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_fire) begin
         s1_rsp_ff.slot_element <= slot.element;
         s1_rsp_ff.req_taken    <= slot.taken;
         s1_rsp_ff.data_valid   <= slot.send;
         s1_rsp_ff.data_word    <= '0;
         s1_rsp_ff.all_done     <= slot.all_done;
         s1_use_mem_ff          <= slot.send && read_in_range;
      end
   end

   // Merge the memory word into the held slot decision
   always_comb begin
      rsp_data_in           = s1_rsp_ff;
      rsp_data_in.data_word = s1_use_mem_ff ? rrrs_pkg::DATA_W'(rd_word_ff) : '0;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
